// File: hw/rtl/scl_pkg.sv
package scl_pkg;

    localparam int MAX_RES        = 3;
    localparam int RES_FIFO_DEPTH = 8;

    typedef enum logic [3:0] {
        MD_IDLE    = 4'd0,
        MD_COMMENT = 4'd1,
        MD_DOT     = 4'd2,
        MD_DOLLAR  = 4'd3,
        MD_AT      = 4'd4,
        MD_DASH    = 4'd5,
        MD_DASH2   = 4'd6,
        MD_PIPE    = 4'd7,
        MD_AMP     = 4'd8,
        MD_NUM     = 4'd9,
        MD_VAR     = 4'd10,
        MD_JOB     = 4'd11,
        MD_FLAG    = 4'd12,
        MD_CMD     = 4'd13,
        MD_STRD    = 4'd14,
        MD_STRS    = 4'd15
    } t_mode;

    typedef enum logic [1:0] {
        K_LEXEME = 2'd0,
        K_EMPTY  = 2'd1,
        K_UNREC  = 2'd2,
        K_END    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        TT_CMD  = 3'd0,
        TT_NUM  = 3'd1,
        TT_STR  = 3'd2,
        TT_VAR  = 3'd3,
        TT_JOB  = 3'd4,
        TT_FLAG = 3'd5,
        TT_OP   = 3'd6
    } t_ttype;

    typedef struct packed {
        t_kind       kind;
        t_ttype      ttype;
        logic [7:0]  out_byte;
        logic        first;
        logic        last;
        logic        done;
    } t_result;

    // results of one item, entries below count are valid
    typedef struct packed {
        logic [1:0]                 count;
        t_result [MAX_RES-1:0]      res;
    } t_push;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQ     = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SQ     = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_DASH   = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_2      = 8'h32;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5a;
    localparam logic [7:0] CH_US     = 8'h5f;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7a;
    localparam logic [7:0] CH_PIPE   = 8'h7c;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
    endfunction

    function automatic logic is_word_start(input logic [7:0] c);
        return is_alpha(c) || (c == CH_US);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_US);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic t_result mk_res(input t_kind k, input t_ttype t, input logic [7:0] b,
                                       input logic f, input logic l, input logic d);
        t_result r;
        r.kind     = k;
        r.ttype    = t;
        r.out_byte = b;
        r.first    = f;
        r.last     = l;
        r.done     = d;
        return r;
    endfunction

    function automatic t_push push_res(input t_push p, input t_result r);
        t_push q;
        q = p;
        if (q.count != 2'd3) begin
            q.res[q.count] = r;
            q.count        = q.count + 2'd1;
        end
        return q;
    endfunction

endpackage

// File: hw/rtl/scl_lexer.sv
module scl_lexer
    import scl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_byte,
    input  logic        i_eoi,
    output t_push       o_push
);

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  held;
        logic        held_valid;
        logic        tok_open;
        t_push       push;
    } t_step;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eoi;

    t_mode       r_mode, n_mode;
    logic [7:0]  r_held, n_held;
    logic        r_held_valid, n_held_valid;
    logic        r_tok_open, n_tok_open;

    t_step       s_step;

    function automatic t_ttype mode_type(input t_mode m);
        t_ttype t;
        case (m)
            MD_NUM:  t = TT_NUM;
            MD_VAR:  t = TT_VAR;
            MD_JOB:  t = TT_JOB;
            MD_FLAG: t = TT_FLAG;
            default: t = TT_CMD;
        endcase
        return t;
    endfunction

    function automatic logic mode_continues(input t_mode m, input logic [7:0] c);
        logic ok;
        if (m == MD_NUM) begin
            ok = is_digit(c) || (c == CH_DOT);
        end else if (m == MD_VAR) begin
            ok = is_word(c) || (c == CH_STAR) || (c == CH_HASH);
        end else begin
            ok = is_word(c);
        end
        return ok;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_in_byte <= i_byte;
            r_in_eoi  <= i_eoi;
        end
    end

    // one full lexer step on the registered item
    always_comb begin
        t_mode       m;
        logic [7:0]  c;
        logic [7:0]  q;
        logic        relex;
        logic        cont;
        t_push       p;
        t_mode       nm;
        logic [7:0]  nhb;
        logic        nhv;
        logic        nto;

        m     = r_mode;
        c     = r_in_byte;
        q     = (r_mode == MD_STRD) ? CH_DQ : CH_SQ;
        relex = 1'b0;
        cont  = 1'b0;
        p     = '0;
        nm    = r_mode;
        nhb   = r_held;
        nhv   = r_held_valid;
        nto   = r_tok_open;

        unique case (m)
            MD_IDLE: begin
                relex = 1'b1;
            end
            MD_COMMENT: begin
                if (c == CH_NL) begin
                    nm = MD_IDLE;  nhv = 1'b0;  nto = 1'b0;
                end
            end
            MD_DOT: begin
                if (is_digit(c)) begin
                    p   = push_res(p, mk_res(K_LEXEME, TT_NUM, nhb, !nto, 1'b0, 1'b0));
                    nto = 1'b1;
                    nhb = c;
                    nm  = MD_NUM;
                end else begin
                    p     = push_res(p, mk_res(K_UNREC, TT_CMD, CH_DOT, 1'b0, 1'b0, 1'b0));
                    relex = 1'b1;
                end
            end
            MD_DOLLAR: begin
                if (c == CH_STAR) begin
                    p  = push_res(p, mk_res(K_LEXEME, TT_VAR, CH_DOLLAR, 1'b1, 1'b0, 1'b0));
                    p  = push_res(p, mk_res(K_LEXEME, TT_VAR, CH_STAR, 1'b0, 1'b1, 1'b0));
                    nm = MD_IDLE;  nhv = 1'b0;  nto = 1'b0;
                end else if (is_word_start(c)) begin
                    nm = MD_VAR;  nhb = c;  nhv = 1'b1;  nto = 1'b0;
                end else begin
                    p     = push_res(p, mk_res(K_UNREC, TT_CMD, CH_DOLLAR, 1'b0, 1'b0, 1'b0));
                    relex = 1'b1;
                end
            end
            MD_AT: begin
                if (is_word_start(c)) begin
                    nm = MD_JOB;  nhb = c;  nhv = 1'b1;  nto = 1'b0;
                end else begin
                    p     = push_res(p, mk_res(K_UNREC, TT_CMD, CH_AT, 1'b0, 1'b0, 1'b0));
                    relex = 1'b1;
                end
            end
            MD_DASH: begin
                if (c == CH_DASH) begin
                    nm = MD_DASH2;  nhv = 1'b0;  nto = 1'b0;
                end else if (is_word_start(c)) begin
                    nm = MD_FLAG;  nhb = c;  nhv = 1'b1;  nto = 1'b0;
                end else begin
                    p     = push_res(p, mk_res(K_UNREC, TT_CMD, CH_DASH, 1'b0, 1'b0, 1'b0));
                    relex = 1'b1;
                end
            end
            MD_DASH2: begin
                if (is_word(c)) begin
                    nm = MD_FLAG;  nhb = c;  nhv = 1'b1;  nto = 1'b0;
                end else begin
                    p     = push_res(p, mk_res(K_EMPTY, TT_FLAG, CH_NUL, 1'b1, 1'b1, 1'b0));
                    relex = 1'b1;
                end
            end
            MD_PIPE: begin
                if ((c == CH_PIPE) || (c == CH_0) || (c == CH_1) || (c == CH_2)) begin
                    p  = push_res(p, mk_res(K_LEXEME, TT_OP, CH_PIPE, 1'b1, 1'b0, 1'b0));
                    p  = push_res(p, mk_res(K_LEXEME, TT_OP, c, 1'b0, 1'b1, 1'b0));
                    nm = MD_IDLE;  nhv = 1'b0;  nto = 1'b0;
                end else begin
                    p     = push_res(p, mk_res(K_LEXEME, TT_OP, CH_PIPE, 1'b1, 1'b1, 1'b0));
                    relex = 1'b1;
                end
            end
            MD_AMP: begin
                if (c == CH_AMP) begin
                    p  = push_res(p, mk_res(K_LEXEME, TT_OP, CH_AMP, 1'b1, 1'b0, 1'b0));
                    p  = push_res(p, mk_res(K_LEXEME, TT_OP, CH_AMP, 1'b0, 1'b1, 1'b0));
                    nm = MD_IDLE;  nhv = 1'b0;  nto = 1'b0;
                end else begin
                    p     = push_res(p, mk_res(K_UNREC, TT_CMD, CH_AMP, 1'b0, 1'b0, 1'b0));
                    relex = 1'b1;
                end
            end
            MD_STRD, MD_STRS: begin
                if (c == q) begin
                    if (nhv) begin
                        p = push_res(p, mk_res(K_LEXEME, TT_STR, nhb, !nto, 1'b1, 1'b0));
                    end else begin
                        p = push_res(p, mk_res(K_EMPTY, TT_STR, CH_NUL, 1'b1, 1'b1, 1'b0));
                    end
                    nm = MD_IDLE;  nhv = 1'b0;  nto = 1'b0;
                end else begin
                    if (nhv) begin
                        p   = push_res(p, mk_res(K_LEXEME, TT_STR, nhb, !nto, 1'b0, 1'b0));
                        nto = 1'b1;
                    end
                    nhb = c;
                    nhv = 1'b1;
                end
            end
            default: begin
                // token body: number, variable, job, flag or command word
                cont = mode_continues(m, c);
                p    = push_res(p, mk_res(K_LEXEME, mode_type(m), nhb, !nto, !cont, 1'b0));
                nto  = 1'b1;
                if (cont) begin
                    nhb = c;
                end else begin
                    relex = 1'b1;
                end
            end
        endcase

        // fresh look at the byte from the between-tokens state
        if (relex) begin
            nm  = MD_IDLE;
            nhv = 1'b0;
            nto = 1'b0;
            if (is_space(c)) begin
                nm = MD_IDLE;
            end else if (c == CH_HASH) begin
                nm = MD_COMMENT;
            end else if (is_digit(c)) begin
                nm = MD_NUM;  nhb = c;  nhv = 1'b1;
            end else if (c == CH_DOT) begin
                nm = MD_DOT;  nhb = c;  nhv = 1'b1;
            end else if (c == CH_DQ) begin
                nm = MD_STRD;
            end else if (c == CH_SQ) begin
                nm = MD_STRS;
            end else if (c == CH_DOLLAR) begin
                nm = MD_DOLLAR;  nhb = c;  nhv = 1'b1;
            end else if (c == CH_AT) begin
                nm = MD_AT;  nhb = c;  nhv = 1'b1;
            end else if (c == CH_DASH) begin
                nm = MD_DASH;  nhb = c;  nhv = 1'b1;
            end else if (is_word_start(c)) begin
                nm = MD_CMD;  nhb = c;  nhv = 1'b1;
            end else if (c == CH_PIPE) begin
                nm = MD_PIPE;  nhb = c;  nhv = 1'b1;
            end else if (c == CH_AMP) begin
                nm = MD_AMP;  nhb = c;  nhv = 1'b1;
            end else if ((c == CH_EQ) || (c == CH_GT) || (c == CH_SEMI)) begin
                p = push_res(p, mk_res(K_LEXEME, TT_OP, c, 1'b1, 1'b1, 1'b0));
            end else begin
                p = push_res(p, mk_res(K_UNREC, TT_CMD, c, 1'b0, 1'b0, 1'b0));
            end
        end

        // end of line closes whatever is pending
        if (r_in_eoi) begin
            unique case (nm)
                MD_IDLE, MD_COMMENT: begin
                    p = p;
                end
                MD_DOT:    p = push_res(p, mk_res(K_UNREC, TT_CMD, CH_DOT, 1'b0, 1'b0, 1'b0));
                MD_DOLLAR: p = push_res(p, mk_res(K_UNREC, TT_CMD, CH_DOLLAR, 1'b0, 1'b0, 1'b0));
                MD_AT:     p = push_res(p, mk_res(K_UNREC, TT_CMD, CH_AT, 1'b0, 1'b0, 1'b0));
                MD_DASH:   p = push_res(p, mk_res(K_UNREC, TT_CMD, CH_DASH, 1'b0, 1'b0, 1'b0));
                MD_AMP:    p = push_res(p, mk_res(K_UNREC, TT_CMD, CH_AMP, 1'b0, 1'b0, 1'b0));
                MD_PIPE:   p = push_res(p, mk_res(K_LEXEME, TT_OP, CH_PIPE, 1'b1, 1'b1, 1'b0));
                MD_DASH2:  p = push_res(p, mk_res(K_EMPTY, TT_FLAG, CH_NUL, 1'b1, 1'b1, 1'b0));
                MD_STRD, MD_STRS: begin
                    if (nhv) begin
                        p = push_res(p, mk_res(K_LEXEME, TT_STR, nhb, !nto, 1'b1, 1'b0));
                    end else begin
                        p = push_res(p, mk_res(K_EMPTY, TT_STR, CH_NUL, 1'b1, 1'b1, 1'b0));
                    end
                end
                default: begin
                    p = push_res(p, mk_res(K_LEXEME, mode_type(nm), nhb, !nto, 1'b1, 1'b0));
                end
            endcase
            p   = push_res(p, mk_res(K_END, TT_CMD, CH_NUL, 1'b0, 1'b0, 1'b1));
            nm  = MD_IDLE;
            nhv = 1'b0;
            nto = 1'b0;
            nhb = CH_NUL;
        end

        s_step.mode       = nm;
        s_step.held       = nhb;
        s_step.held_valid = nhv;
        s_step.tok_open   = nto;
        s_step.push       = p;
    end

    // next state
    always_comb begin
        if (r_in_valid) begin
            n_mode       = s_step.mode;
            n_held       = s_step.held;
            n_held_valid = s_step.held_valid;
            n_tok_open   = s_step.tok_open;
        end else begin
            n_mode       = r_mode;
            n_held       = r_held;
            n_held_valid = r_held_valid;
            n_tok_open   = r_tok_open;
        end
    end

    // outputs
    always_comb begin
        o_push = s_step.push;
        if (!r_in_valid) begin
            o_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MD_IDLE;
            r_held       <= CH_NUL;
            r_held_valid <= 1'b0;
            r_tok_open   <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_tok_open   <= n_tok_open;
        end
    end

endmodule

// File: hw/rtl/scl_res_fifo.sv
module scl_res_fifo
    import scl_pkg::*;
#(
    parameter int DEPTH = RES_FIFO_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_push                       i_push,
    input  logic                        i_ready,
    output logic                        o_valid,
    output t_result                     o_res,
    output logic [$clog2(DEPTH+1)-1:0]  o_level
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_result            r_mem [DEPTH];
    logic [AW-1:0]      r_wr, n_wr;
    logic [AW-1:0]      r_rd, n_rd;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      s_widx [MAX_RES];
    logic               s_pop;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [1:0] k);
        logic [AW+1:0] s;
        s = {2'b00, a} + {{AW{1'b0}}, k};
        if (s >= (AW+2)'(DEPTH)) begin
            s = s - (AW+2)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign s_pop   = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd];
    assign o_level = r_count;

    always_comb begin
        for (int k = 0; k < MAX_RES; k++) begin
            s_widx[k] = wrap_add(r_wr, 2'(k));
        end
        n_wr = wrap_add(r_wr, i_push.count);
        n_rd = wrap_add(r_rd, {1'b0, s_pop});
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (2'(k) < i_push.count) begin
                r_mem[s_widx[k]] <= i_push.res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= r_count + CW'(i_push.count) - CW'(s_pop);
        end
    end

endmodule

// File: hw/rtl/shell_command_lexer_unit.sv
// shell command lexer: splits a command line, one byte per item, into tagged lexeme items
//
// input channel (s_axis): tdata[7:0] is the character, tlast marks the final byte of a line
// output channel (m_axis): one result per item; tdata carries the lexeme or unrecognized
//   byte and the first/last-of-token marks, tuser the result kind and token class,
//   tlast is set only on the end-of-line marker that closes every line
// path: results of a byte pass the input register, then the lexer step writes them into
//   the result queue, from whose head they are offered
// throughput: one byte per cycle while each byte yields at most one result and the
//   receiver keeps up; a byte can yield up to three results, which leave one per cycle
// the result queue holds FIFO_DEPTH results; s_axis_tready drops while fewer than
//   2 * MAX_RES entries are free, so a stalled receiver backs up into the sender
//   with nothing lost
// reset (i_rst_n low, synchronous) empties the queue and returns the lexer to the
//   between-tokens state with nothing held
module shell_command_lexer_unit
    import scl_pkg::*;
#(
    parameter int FIFO_DEPTH = RES_FIFO_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] char_byte
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [15:0]  m_axis_tdata,   // [7:0] out_byte, [8] token_first, [9] token_last
    output logic [4:0]   m_axis_tuser,   // [1:0] kind, [4:2] tok_class
    output logic         m_axis_tlast
);

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_push          s_push;
    t_result        s_res;
    logic [CW-1:0]  s_level;
    logic           s_accept;

    // room for the item in the input register and the one being accepted
    assign s_axis_tready = (s_level <= CW'(FIFO_DEPTH - 2 * MAX_RES));
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    scl_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_accept),
        .i_byte  (s_axis_tdata),
        .i_eoi   (s_axis_tlast),
        .o_push  (s_push)
    );

    scl_res_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (s_res),
        .o_level (s_level)
    );

    assign m_axis_tdata = {6'b0, s_res.last, s_res.first, s_res.out_byte};
    assign m_axis_tuser = {s_res.ttype, s_res.kind};
    assign m_axis_tlast = s_res.done;

endmodule
